### rtl/sip_pkg.sv
// superframe index parser: shared types, constants and codes
// used by every module of the block; depends on nothing else
package sip_pkg;

   localparam int LENGTH_BITS_DEF = 24;
   localparam int TAIL_DEPTH      = 34;
   localparam int ADDR_W          = $clog2(TAIL_DEPTH);
   localparam int IDX_W           = 6;
   localparam int OUT_W           = 24;
   localparam int SIZE_W          = 32;
   localparam int FRAME_W         = 3;
   localparam int MAG_W           = 2;

   localparam logic [7:0] MARKER_MASK = 8'he0;
   localparam logic [7:0] MARKER_SYNC = 8'hc0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               is_superframe;
      logic [FRAME_W-1:0] frame_number;
      logic [OUT_W-1:0]   frame_offset;
      logic [OUT_W-1:0]   frame_size;
      logic               last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LEAD_READ,
      ST_LEAD_TAKE,
      ST_SIZE_READ,
      ST_SIZE_TAKE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_WHOLE,
      OUT_ERROR,
      OUT_FRAME
   } out_sel_type;

   typedef struct packed {
      logic        take_byte;
      logic        load_lead;
      logic        load_sizes;
      logic        take_size;
      logic        emit_step;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic overlong;
      logic no_marker;
      logic too_short;
      logic lead_match;
      logic size_done;
      logic size_too_big;
      logic last_frame;
      logic emit_last;
   } stat_type;

endpackage

### rtl/superframe_index_parser.sv
// superframe index parser top level: one byte word per cycle in while not busy, frame descriptors out
// a final byte without an index, or an overlong buffer, is judged in ST_CHECK and its result
// is then registered; with an index, busy stays high while the tail memory's single read port
// reads each index byte in ST_SIZE_READ and takes it in ST_SIZE_TAKE, before frames are emitted
// throughput: 1 byte per cycle while not busy; results are never stalled
// reset (synchronous, active high) clears byte count, write pointer, state and strobe; tail memory is not cleared
module superframe_index_parser #(
   parameter int LENGTH_BITS = sip_pkg::LENGTH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sip_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sip_pkg::rsp_type rsp_data
);

   sip_pkg::cmd_type  cmd;
   sip_pkg::stat_type stat;

   sip_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .end_of_buffer (req_data.end_of_buffer),
      .busy          (busy),
      .stat          (stat),
      .cmd           (cmd)
   );

   sip_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/sip_ctrl.sv
// superframe index parser: controller state machine
// depends on sip_pkg; drives the datapath by command, reads its status
module sip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               end_of_buffer,
   output logic               busy,
   input  sip_pkg::stat_type  stat,
   output sip_pkg::cmd_type   cmd
);

   sip_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sip_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      busy          = (state_ff != sip_pkg::ST_IDLE);
      cmd.take_byte  = 1'b0;
      cmd.load_lead  = 1'b0;
      cmd.load_sizes = 1'b0;
      cmd.take_size  = 1'b0;
      cmd.emit_step  = 1'b0;
      cmd.out_sel    = sip_pkg::OUT_NONE;
      case (state_ff)
         sip_pkg::ST_IDLE: begin
            if (start) begin
               cmd.take_byte = 1'b1;
               if (end_of_buffer) begin
                  state_in = sip_pkg::ST_CHECK;
               end
            end
         end
         sip_pkg::ST_CHECK: begin
            if (stat.overlong) begin
               cmd.out_sel = sip_pkg::OUT_ERROR;
               state_in    = sip_pkg::ST_IDLE;
            end else if (stat.no_marker) begin
               cmd.out_sel = sip_pkg::OUT_WHOLE;
               state_in    = sip_pkg::ST_IDLE;
            end else if (stat.too_short) begin
               cmd.out_sel = sip_pkg::OUT_ERROR;
               state_in    = sip_pkg::ST_IDLE;
            end else begin
               cmd.load_lead = 1'b1;
               state_in      = sip_pkg::ST_LEAD_READ;
            end
         end
         sip_pkg::ST_LEAD_READ: begin
            state_in = sip_pkg::ST_LEAD_TAKE;
         end
         sip_pkg::ST_LEAD_TAKE: begin
            if (!stat.lead_match) begin
               cmd.out_sel = sip_pkg::OUT_ERROR;
               state_in    = sip_pkg::ST_IDLE;
            end else begin
               cmd.load_sizes = 1'b1;
               state_in       = sip_pkg::ST_SIZE_READ;
            end
         end
         sip_pkg::ST_SIZE_READ: begin
            state_in = sip_pkg::ST_SIZE_TAKE;
         end
         sip_pkg::ST_SIZE_TAKE: begin
            cmd.take_size = 1'b1;
            if (stat.size_done && stat.size_too_big) begin
               cmd.out_sel = sip_pkg::OUT_ERROR;
               state_in    = sip_pkg::ST_IDLE;
            end else if (stat.size_done && stat.last_frame) begin
               state_in = sip_pkg::ST_EMIT;
            end else begin
               state_in = sip_pkg::ST_SIZE_READ;
            end
         end
         sip_pkg::ST_EMIT: begin
            cmd.out_sel   = sip_pkg::OUT_FRAME;
            cmd.emit_step = 1'b1;
            if (stat.emit_last) begin
               state_in = sip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sip_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/sip_datapath.sv
// superframe index parser: byte counter, tail memory, size table and result register
// depends on sip_pkg; commanded by sip_ctrl
module sip_datapath #(
   parameter int LENGTH_BITS = sip_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  sip_pkg::req_type  req_data,
   input  sip_pkg::cmd_type  cmd,
   output sip_pkg::stat_type stat,
   output logic              rsp_strobe,
   output sip_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = LENGTH_BITS + 1;
   localparam int CMP_W = LENGTH_BITS + sip_pkg::SIZE_W;
   localparam int NFRM  = 1 << sip_pkg::FRAME_W;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(1) << LENGTH_BITS;

   // tail memory, circular, written once per word
   logic [7:0] mem [sip_pkg::TAIL_DEPTH];

   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              n_ff;
   logic [CNT_W-1:0]              n_next;
   logic [sip_pkg::ADDR_W-1:0]    wr_ptr_ff;
   logic [sip_pkg::ADDR_W-1:0]    newest_ff;
   logic [sip_pkg::ADDR_W-1:0]    pos_ff;
   logic [sip_pkg::ADDR_W-1:0]    rd_addr;
   logic [sip_pkg::ADDR_W:0]      rd_wrap;
   logic [7:0]                    rd_data_ff;
   logic [7:0]                    marker_ff;
   logic [sip_pkg::FRAME_W-1:0]   frm_ff;
   logic [sip_pkg::MAG_W-1:0]     j_ff;
   logic [sip_pkg::FRAME_W-1:0]   idx_ff;
   logic [sip_pkg::SIZE_W-1:0]    sz_ff;
   logic [sip_pkg::SIZE_W-1:0]    sz_full;
   logic [LENGTH_BITS-1:0]        left_ff;
   logic [LENGTH_BITS-1:0]        offset_ff;
   logic [LENGTH_BITS-1:0]        sizes_ff [NFRM];
   logic [sip_pkg::IDX_W-1:0]     index_len;
   logic [sip_pkg::FRAME_W:0]     frames;
   logic [sip_pkg::MAG_W:0]       mag;
   logic                          rsp_strobe_ff;
   sip_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   assign n_next = (count_ff == CAP) ? CAP : count_ff + CNT_W'(1);

   assign frames     = {1'b0, marker_ff[2:0]} + (sip_pkg::FRAME_W + 1)'(1);
   assign mag        = {1'b0, marker_ff[4:3]} + (sip_pkg::MAG_W + 1)'(1);
   assign index_len  = sip_pkg::IDX_W'(2)
                     + sip_pkg::IDX_W'(mag) * sip_pkg::IDX_W'(frames);

   // byte at distance pos_ff behind the newest one
   assign rd_wrap = {1'b0, newest_ff} + (sip_pkg::ADDR_W + 1)'(sip_pkg::TAIL_DEPTH)
                  - {1'b0, pos_ff};
   assign rd_addr = (newest_ff >= pos_ff) ? newest_ff - pos_ff
                                          : rd_wrap[sip_pkg::ADDR_W-1:0];

   // little-endian size byte merged in
   assign sz_full = sz_ff | (sip_pkg::SIZE_W'(rd_data_ff) << {j_ff, 3'b000});

   always_comb begin
      stat.overlong     = n_ff[LENGTH_BITS];
      stat.no_marker    = ((marker_ff & sip_pkg::MARKER_MASK) != sip_pkg::MARKER_SYNC);
      stat.too_short    = (n_ff < CNT_W'(index_len))
                       || (index_len > sip_pkg::IDX_W'(sip_pkg::TAIL_DEPTH));
      stat.lead_match   = (rd_data_ff == marker_ff);
      stat.size_done    = (j_ff == marker_ff[4:3]);
      stat.size_too_big = (CMP_W'(sz_full) > CMP_W'(left_ff));
      stat.last_frame   = (frm_ff == marker_ff[2:0]);
      stat.emit_last    = (idx_ff == marker_ff[2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
      end else if (cmd.take_byte) begin
         wr_ptr_ff <= (wr_ptr_ff == sip_pkg::ADDR_W'(sip_pkg::TAIL_DEPTH - 1))
                    ? '0 : wr_ptr_ff + sip_pkg::ADDR_W'(1);
         count_ff  <= req_data.end_of_buffer ? '0 : n_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         mem[wr_ptr_ff] <= req_data.data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && req_data.end_of_buffer) begin
         marker_ff <= req_data.data_byte;
         n_ff      <= n_next;
         newest_ff <= wr_ptr_ff;
      end
      if (cmd.load_lead) begin
         pos_ff <= sip_pkg::ADDR_W'(index_len - sip_pkg::IDX_W'(1));
      end
      if (cmd.load_sizes) begin
         pos_ff    <= sip_pkg::ADDR_W'(index_len - sip_pkg::IDX_W'(2));
         left_ff   <= LENGTH_BITS'(n_ff - CNT_W'(index_len));
         sz_ff     <= '0;
         j_ff      <= '0;
         frm_ff    <= '0;
         idx_ff    <= '0;
         offset_ff <= '0;
      end
      if (cmd.take_size) begin
         pos_ff <= pos_ff - sip_pkg::ADDR_W'(1);
         if (stat.size_done) begin
            sizes_ff[frm_ff] <= LENGTH_BITS'(sz_full);
            left_ff          <= LENGTH_BITS'(CMP_W'(left_ff) - CMP_W'(sz_full));
            frm_ff           <= frm_ff + sip_pkg::FRAME_W'(1);
            sz_ff            <= '0;
            j_ff             <= '0;
         end else begin
            sz_ff <= sz_full;
            j_ff  <= j_ff + sip_pkg::MAG_W'(1);
         end
      end
      if (cmd.emit_step) begin
         idx_ff    <= idx_ff + sip_pkg::FRAME_W'(1);
         offset_ff <= offset_ff + sizes_ff[idx_ff];
      end
   end

   always_comb begin
      rsp_data_in = '0;
      case (cmd.out_sel)
         sip_pkg::OUT_WHOLE: begin
            rsp_data_in.frame_size  = sip_pkg::OUT_W'(n_ff);
            rsp_data_in.last_result = 1'b1;
         end
         sip_pkg::OUT_ERROR: begin
            rsp_data_in.status      = 1'b1;
            rsp_data_in.last_result = 1'b1;
         end
         sip_pkg::OUT_FRAME: begin
            rsp_data_in.is_superframe = 1'b1;
            rsp_data_in.frame_number  = idx_ff;
            rsp_data_in.frame_offset  = sip_pkg::OUT_W'(offset_ff);
            rsp_data_in.frame_size    = sip_pkg::OUT_W'(sizes_ff[idx_ff]);
            rsp_data_in.last_result   = stat.emit_last;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.out_sel != sip_pkg::OUT_NONE);
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### rtl/sip_checker.sv
// superframe index parser: port-level checker and its bind to the top level
// depends on sip_pkg and superframe_index_parser
module sip_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sip_pkg::req_type req_data,
   input logic             rsp_strobe,
   input sip_pkg::rsp_type rsp_data
);

   // a final word always starts a parse
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.end_of_buffer |=> busy)
      else $error("final word did not raise busy");

   // error results are single and carry no frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status |->
         rsp_data.last_result && !rsp_data.is_superframe
         && rsp_data.frame_size == '0 && rsp_data.frame_offset == '0)
      else $error("malformed error result");

   // frames of one superframe come out back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |=> rsp_strobe)
      else $error("gap inside a frame list");

   // numbering advances by one within a superframe
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |=>
         rsp_data.frame_number == $past(rsp_data.frame_number) + 3'd1)
      else $error("frame number did not advance");

   // only superframe results come in groups
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |-> rsp_data.is_superframe)
      else $error("non-final result outside a superframe");

endmodule

bind superframe_index_parser sip_checker u_sip_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### tb/superframe_index_parser_tb.sv
// testbench for superframe_index_parser: byte words in, frame descriptors out,
// checked against a behavioral index parser kept inside this file; uses sip_pkg
`timescale 1ns / 1ps

module superframe_index_parser_tb;

   // length counter width used by this bench
   localparam int          LEN_BITS    = 16;
   localparam int          TAIL_N      = sip_pkg::TAIL_DEPTH;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int          DRAIN_WAIT  = 100;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   sip_pkg::req_type req_data;
   logic             rsp_strobe;
   sip_pkg::rsp_type rsp_data;

   // behavioral parser state
   int unsigned      run_length = 0;
   logic [7:0]       tail_q [TAIL_N] = '{default: '0};
   sip_pkg::rsp_type frames_due [$];
   sip_pkg::rsp_type oldest;

   // stimulus scratch
   logic [7:0]  buf_bytes [$];
   int unsigned frame_len [8];
   bit          gaps_on = 1'b1;

   int unsigned mismatches = 0;
   int unsigned results_predicted = 0;
   int unsigned results_checked = 0;
   int unsigned bytes_sent = 0;
   int unsigned buffers_sent = 0;

   superframe_index_parser #(.LENGTH_BITS(LEN_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void push_fault();
      sip_pkg::rsp_type r;
      r = '0;
      r.status = 1'b1;
      r.last_result = 1'b1;
      frames_due = {frames_due, r};
      results_predicted++;
   endfunction

   // descriptors for the buffer that just ended, n bytes long (saturated)
   function automatic void split_buffer(input int unsigned n);
      logic [7:0]       marker;
      int unsigned      frame_cnt, size_bytes, idx_len, remaining, at, sz, offset;
      int unsigned      sizes [8];
      sip_pkg::rsp_type r;
      marker = tail_q[0];
      if (n > (1 << LEN_BITS) - 1) begin
         push_fault();
         return;
      end
      if ((marker & sip_pkg::MARKER_MASK) != sip_pkg::MARKER_SYNC) begin
         r = '0;
         r.frame_size = sip_pkg::OUT_W'(n);
         r.last_result = 1'b1;
         frames_due = {frames_due, r};
         results_predicted++;
         return;
      end
      frame_cnt = int'(marker[2:0]) + 1;
      size_bytes = int'(marker[4:3]) + 1;
      idx_len = 2 + size_bytes * frame_cnt;
      if (n < idx_len || idx_len > TAIL_N) begin
         push_fault();
         return;
      end
      if (tail_q[idx_len-1] != marker) begin
         push_fault();
         return;
      end
      remaining = n - idx_len;
      for (int i = 0; i < frame_cnt; i++) begin
         sz = 0;
         for (int j = 0; j < size_bytes; j++) begin
            at = idx_len - 2 - i * size_bytes - j;
            sz = sz | (32'(tail_q[at]) << (8 * j));
         end
         if (sz > remaining) begin
            push_fault();
            return;
         end
         remaining -= sz;
         sizes[i] = sz;
      end
      offset = 0;
      for (int i = 0; i < frame_cnt; i++) begin
         r = '0;
         r.is_superframe = 1'b1;
         r.frame_number = sip_pkg::FRAME_W'(i);
         r.frame_offset = sip_pkg::OUT_W'(offset);
         r.frame_size = sip_pkg::OUT_W'(sizes[i]);
         r.last_result = (i + 1 == frame_cnt);
         frames_due = {frames_due, r};
         results_predicted++;
         offset += sizes[i];
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // result check first, then the accepted byte word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            results_checked++;
            if (frames_due.size() == 0) begin
               $error("result with nothing outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               oldest = frames_due[0];
               frames_due.delete(0);
               check_field("status", 32'(oldest.status), 32'(rsp_data.status));
               check_field("is_superframe", 32'(oldest.is_superframe),
                           32'(rsp_data.is_superframe));
               check_field("frame_number", 32'(oldest.frame_number),
                           32'(rsp_data.frame_number));
               check_field("frame_offset", 32'(oldest.frame_offset),
                           32'(rsp_data.frame_offset));
               check_field("frame_size", 32'(oldest.frame_size), 32'(rsp_data.frame_size));
               check_field("last_result", 32'(oldest.last_result),
                           32'(rsp_data.last_result));
            end
         end
         if (start && busy === 1'b0) begin
            for (int k = TAIL_N - 1; k > 0; k--) tail_q[k] = tail_q[k-1];
            tail_q[0] = req_data.data_byte;
            if (run_length < (1 << LEN_BITS)) run_length++;
            if (req_data.end_of_buffer) begin
               split_buffer(run_length);
               run_length = 0;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: nothing moved for %0d cycles", quiet);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int unsigned gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= sip_pkg::req_type'{data_byte: value, end_of_buffer: is_last};
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic send_buffer();
      for (int k = 0; k < buf_bytes.size(); k++)
         send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
      bytes_sent += buf_bytes.size();
      buffers_sent++;
      buf_bytes.delete();
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (frames_due.size() != 0);
   endtask

   function automatic void add_payload(input int unsigned n);
      for (int unsigned k = 0; k < n; k++) buf_bytes = {buf_bytes, 8'($urandom)};
   endfunction

   // marker, little-endian sizes from frame_len, marker
   function automatic void add_index(input int unsigned fc, input int unsigned sb);
      logic [7:0] marker;
      marker = sip_pkg::MARKER_SYNC | 8'((sb - 1) << 3) | 8'(fc - 1);
      buf_bytes = {buf_bytes, marker};
      for (int i = 0; i < fc; i++)
         for (int j = 0; j < sb; j++)
            buf_bytes = {buf_bytes, 8'(frame_len[i] >> (8 * j))};
      buf_bytes = {buf_bytes, marker};
   endfunction

   function automatic int unsigned index_len(input int unsigned fc, input int unsigned sb);
      return 2 + fc * sb;
   endfunction

   // random well-formed superframe, sometimes with uncovered bytes
   function automatic void add_random_superframe();
      int unsigned fc, sb, total;
      fc = $urandom_range(1, 8);
      sb = $urandom_range(1, 4);
      total = 0;
      for (int i = 0; i < fc; i++) begin
         if ($urandom_range(0, 15) == 0) frame_len[i] = $urandom_range(9, 40);
         else frame_len[i] = $urandom_range(0, 8);
         total += frame_len[i];
      end
      if ($urandom_range(0, 3) == 0) total += $urandom_range(1, 4);
      add_payload(total);
      add_index(fc, sb);
   endfunction

   task automatic test_plain_buffers();
      // plain buffer, top bits clear
      add_payload(6);
      buf_bytes = {buf_bytes, 8'h00};
      send_buffer();
      buf_bytes = {buf_bytes, 8'h5a};
      send_buffer();
      add_payload(4);
      buf_bytes = {buf_bytes, 8'he0};
      send_buffer();
      add_payload(2);
      buf_bytes = {buf_bytes, 8'ha0};
      send_buffer();
      add_payload(1);
      buf_bytes = {buf_bytes, 8'hff};
      send_buffer();
      wait_drained();
   endtask

   task automatic test_superframes();
      frame_len = '{5, 0, 0, 0, 0, 0, 0, 0};
      add_payload(5);
      add_index(1, 1);
      send_buffer();
      // widest index: eight frames, four size bytes each
      frame_len = '{0, 1, 0, 2, 0, 0, 1, 0};
      add_payload(4);
      add_index(8, 4);
      send_buffer();
      // empty frames plus trailing bytes no frame covers
      frame_len = '{3, 0, 1, 0, 2, 4, 0, 1};
      add_payload(14);
      add_index(8, 1);
      send_buffer();
      // index alone, buffer exactly its length
      frame_len = '{0, 0, 0, 0, 0, 0, 0, 0};
      add_index(2, 3);
      send_buffer();
      wait_drained();
   endtask

   task automatic test_bad_indexes();
      buf_bytes = {buf_bytes, sip_pkg::MARKER_SYNC};
      send_buffer();
      add_payload(4);
      buf_bytes = {buf_bytes, 8'hdf};
      send_buffer();
      // leading marker differs in its frame count bits
      frame_len = '{1, 1, 0, 0, 0, 0, 0, 0};
      add_payload(2);
      add_index(2, 1);
      buf_bytes[buf_bytes.size() - 4] ^= 8'h01;
      send_buffer();
      frame_len = '{5, 1, 0, 0, 0, 0, 0, 0};
      add_payload(4);
      add_index(2, 1);
      send_buffer();
      frame_len = '{2, 2, 3, 0, 0, 0, 0, 0};
      add_payload(6);
      add_index(3, 2);
      send_buffer();
      // one byte short of the index
      frame_len = '{0, 0, 0, 0, 0, 0, 0, 0};
      add_index(1, 2);
      buf_bytes.delete(0);
      send_buffer();
      wait_drained();
   endtask

   task automatic test_random_buffers();
      int unsigned bytes_at_start, cut, pos;
      bytes_at_start = bytes_sent;
      while (bytes_sent - bytes_at_start < 75) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               add_random_superframe();
            end
            6: begin
               add_payload($urandom_range(1, 40));
            end
            7: begin
               // damage one index byte
               add_random_superframe();
               pos = buf_bytes.size() - 1 - $urandom_range(0,
                     index_len(int'(buf_bytes[$][2:0]) + 1, int'(buf_bytes[$][4:3]) + 1) - 1);
               buf_bytes[pos] ^= 8'($urandom_range(1, 255));
            end
            8: begin
               // drop bytes from the front
               add_random_superframe();
               cut = $urandom_range(1, buf_bytes.size() - 1);
               repeat (cut) buf_bytes.delete(0);
            end
            default: begin
               add_payload($urandom_range(0, 9));
               buf_bytes = {buf_bytes, sip_pkg::MARKER_SYNC | 8'($urandom_range(0, 31))};
            end
         endcase
         send_buffer();
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_plain_buffers();
      test_superframes();
      test_bad_indexes();
      test_random_buffers();
      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("covered %0d buffers, %0d bytes: plain, superframe, bad index and random",
               buffers_sent, bytes_sent);
      $display("checked %0d results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
